### design/mi_pkg.sv
// Package for the modular inverse unit: sequencer state type and register codes.
// No dependencies; used by modular_inverse_unit.
`default_nettype none

package mi_pkg;

   // width of each result field
   localparam int OUT_W = 32;

   // register index within the configuration space
   localparam logic REG_MODULUS = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

### design/modular_inverse_unit.sv
// Modular inverse by the extended Euclidean algorithm, one shared divide/multiply datapath.
// Depends on mi_pkg (state type, register codes, result width).
//
// channel   direction  handshake                  payload
// request   in         start, busy                req_value
// response  out        rsp_strobe                 rsp_inverse, rsp_prior_coefficient
// config    in/out     psel, penable, pwrite,     paddr, pwdata, prdata
//                      pready
//
// A round with a nonzero remainder runs WIDTH restoring divide steps, WIDTH
// shift-and-add modular multiply steps and one coefficient update. The last
// divide runs WIDTH steps and ends the item with a zero remainder and the strobe.
// A zero value or a modulus below two gives its result in the cycle after transfer.
// busy is low again in the strobe cycle. Reset clears the sequencer and sets the
// modulus to two; the receiver cannot stall the strobe.
`default_nettype none

module modular_inverse_unit #(
   parameter int WIDTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [WIDTH-1:0]                        req_value,
   // response
   output logic                                         rsp_strobe,
   output logic [mi_pkg::OUT_W-1:0]                     rsp_inverse,
   output logic [mi_pkg::OUT_W-1:0]                     rsp_prior_coefficient,
   // configuration
   input  wire logic                                    psel,
   input  wire logic                                    penable,
   input  wire logic                                    pwrite,
   input  wire logic [((WIDTH > 32) ? 3 : 2):0]         paddr,
   input  wire logic [((WIDTH > 32) ? 64 : 32)-1:0]     pwdata,
   output logic [((WIDTH > 32) ? 64 : 32)-1:0]          prdata,
   output logic                                         pready
);

   localparam int DataW    = (WIDTH > 32) ? 64 : 32;
   localparam int ByteBits = (WIDTH > 32) ? 3 : 2;
   localparam int CntW     = $clog2(WIDTH);
   localparam int OutW     = mi_pkg::OUT_W;

   mi_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] lo_ff, lo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] cur_ff, cur_in;
   logic [WIDTH-1:0] prev_ff, prev_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [OutW-1:0]  rsp_inverse_ff, rsp_inverse_in;
   logic [OutW-1:0]  rsp_prior_ff, rsp_prior_in;

   logic             accept;
   logic             cfg_write;
   logic             last_step;
   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   rem_sub;
   logic             rem_ge;
   logic [WIDTH-1:0] rem_step;
   logic [WIDTH+1:0] mul_sum;
   logic [WIDTH+1:0] mul_n1;
   logic [WIDTH+1:0] mul_n2;
   logic [WIDTH-1:0] mul_step;
   logic [WIDTH-1:0] upd_next;

   assign accept    = start && !busy;
   assign busy      = (state_ff != mi_pkg::ST_IDLE);
   assign cfg_write = psel && penable && pwrite && pready
                      && (paddr[ByteBits] == mi_pkg::REG_MODULUS);
   assign last_step = (cnt_ff == CntW'(WIDTH - 1));

   assign pready = 1'b1;
   assign prdata = (paddr[ByteBits] == mi_pkg::REG_MODULUS) ? DataW'(modulus_ff) : '0;

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_inverse           = rsp_inverse_ff;
   assign rsp_prior_coefficient = rsp_prior_ff;

   // restoring divide step
   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign rem_sub   = rem_shift - {1'b0, lo_ff};
   assign rem_ge    = (rem_shift >= {1'b0, lo_ff});
   assign rem_step  = rem_ge ? rem_sub[WIDTH-1:0] : rem_shift[WIDTH-1:0];

   // modular multiply step: acc = 2*acc + bit*cur, reduced below the modulus
   assign mul_n1   = (WIDTH+2)'(modulus_ff);
   assign mul_n2   = {1'b0, modulus_ff, 1'b0};
   assign mul_sum  = {1'b0, acc_ff, 1'b0}
                     + (quo_ff[WIDTH-1] ? (WIDTH+2)'(cur_ff) : '0);
   always_comb begin
      if (mul_sum >= mul_n2) begin
         mul_step = WIDTH'(mul_sum - mul_n2);
      end else if (mul_sum >= mul_n1) begin
         mul_step = WIDTH'(mul_sum - mul_n1);
      end else begin
         mul_step = mul_sum[WIDTH-1:0];
      end
   end

   // coefficient update: (prev - acc) mod n
   assign upd_next = prev_ff - acc_ff + ((prev_ff < acc_ff) ? modulus_ff : '0);

   always_comb begin
      state_in       = state_ff;
      modulus_in     = modulus_ff;
      lo_in          = lo_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      acc_in         = acc_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      cnt_in         = cnt_ff;
      rsp_strobe_in  = 1'b0;
      rsp_inverse_in = rsp_inverse_ff;
      rsp_prior_in   = rsp_prior_ff;

      if (cfg_write) begin
         modulus_in = WIDTH'(pwdata);
      end

      case (state_ff)
         mi_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_value == '0) || (modulus_ff < WIDTH'(2))) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_inverse_in = '0;
                  rsp_prior_in   = '0;
               end else begin
                  quo_in   = modulus_ff;
                  lo_in    = req_value;
                  rem_in   = '0;
                  prev_in  = '0;
                  cur_in   = WIDTH'(1);
                  cnt_in   = '0;
                  state_in = mi_pkg::ST_DIV;
               end
            end
         end
         mi_pkg::ST_DIV: begin
            rem_in = rem_step;
            quo_in = {quo_ff[WIDTH-2:0], rem_ge};
            cnt_in = cnt_ff + CntW'(1);
            if (last_step) begin
               cnt_in = '0;
               acc_in = '0;
               if (rem_step == '0) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_inverse_in = OutW'(cur_ff);
                  rsp_prior_in   = OutW'(prev_ff);
                  state_in       = mi_pkg::ST_IDLE;
               end else begin
                  state_in = mi_pkg::ST_MUL;
               end
            end
         end
         mi_pkg::ST_MUL: begin
            acc_in = mul_step;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CntW'(1);
            if (last_step) begin
               cnt_in   = '0;
               state_in = mi_pkg::ST_UPD;
            end
         end
         mi_pkg::ST_UPD: begin
            prev_in  = cur_ff;
            cur_in   = upd_next;
            quo_in   = lo_ff;
            lo_in    = rem_ff;
            rem_in   = '0;
            state_in = mi_pkg::ST_DIV;
         end
         default: begin
            state_in = mi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mi_pkg::ST_IDLE;
         modulus_ff    <= WIDTH'(2);
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      acc_ff         <= acc_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_prior_ff   <= rsp_prior_in;
   end

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mi_pkg::ST_DIV) |-> (lo_ff != '0))
      else $error("divisor is zero during a divide round");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mi_pkg::ST_DIV) |-> (rem_ff < lo_ff))
      else $error("partial remainder not below divisor");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mi_pkg::ST_MUL || state_ff == mi_pkg::ST_UPD)
      |-> (acc_ff < modulus_ff))
      else $error("multiply accumulator not reduced");

   a_coeff_reduced: assert property (@(posedge clock) disable iff (reset)
      busy |-> ((cur_ff < modulus_ff) && (prev_ff < modulus_ff)))
      else $error("coefficient not reduced");

   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe_ff) |-> ($past(accept) || $past(busy)))
      else $error("result strobe without a transfer");

endmodule

`default_nettype wire
